// ----- sv/sliding_window_start_limiter_top_defines.svh -----
// Assertion macros for the sliding window start limiter.
// Included by the RTL files that carry concurrent checks; needs clk and rst in scope.
`ifndef SLIDING_WINDOW_START_LIMITER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_START_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define SWSL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define SWSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/swsl_pkg.sv -----
// Shared types and constants of the sliding window start limiter.
// No dependencies; imported by the top level.
package swsl_pkg;

  // Field widths of the request and result
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned WINDOW_W = 20;
  localparam int unsigned BURST_W  = 8;
  localparam int unsigned KEPT_W   = 7;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RES_DATA_W = 16;

  // Register reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd10;
  localparam logic [BURST_W-1:0]  BURST_RESET  = 8'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST  = 8'd1;

  // Request kinds
  localparam logic CMD_ATTEMPT = 1'b0;
  localparam logic CMD_CHECK   = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PRUNE,
    S_DECIDE,
    S_RESULT
  } state_t;

endpackage

// ----- sv/swsl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the start time log.
module swsl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sliding_window_start_limiter_top.sv -----
// Sliding window start limiter: request sequencer, log walk and result register.
// Depends on swsl_pkg, swsl_ram and sliding_window_start_limiter_top_defines.svh.
//
// Usage:
//   Requests enter on s_tvalid/s_tready: s_tuser is the command (attempt or check),
//   s_tdata the current time in seconds. One result per request leaves on
//   m_tvalid/m_tready with allowed, limit_hit and the kept count.
//   Registers (window_seconds, burst_limit) are written on cfg_valid/cfg_ready,
//   which is always ready; write them only while no request is in flight.
// Timing:
//   One stored entry is read per cycle; each compare follows its registered read, and
//   kept entries are written back in order. S_DECIDE then decides and appends, and
//   S_RESULT loads the result once the output register is free; the next request is
//   accepted after that. An empty log skips the walk, and a check with limiting off
//   skips both the walk and the decision.
// Reset:
//   rst (synchronous) empties the log, restores window 10 and burst 5, and drops
//   any pending result.
// Stall:
//   A finished result waits in the output register; the next request is still
//   accepted and processed, and only its own result waits for the register.
module sliding_window_start_limiter_top #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [swsl_pkg::NOW_W-1:0]        s_tdata,   // [31:0] now_seconds
  input  logic                              s_tuser,   // [0] cmd
  // result channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [swsl_pkg::RES_DATA_W-1:0]   m_tdata,   // [0] allowed, [1] limit_hit,
                                                       // [8:2] kept_count, [15:9] zero
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swsl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swsl_pkg::*;

  `include "sliding_window_start_limiter_top_defines.svh"

  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

  state_t state, state_next;

  logic                 cmd_q;
  logic [NOW_W-1:0]     now_q;
  logic [CW-1:0]        total;
  logic [CW-1:0]        kept;
  logic [CW-1:0]        rd_idx;
  logic                 rd_pend;
  logic [WINDOW_W-1:0]  window_q;
  logic [BURST_W-1:0]   burst_q;

  logic                 accept;
  logic                 bypass;
  logic                 issue;
  logic [NOW_W:0]       diff;
  logic                 keep;
  logic                 hit_now;
  logic                 room;
  logic                 append;
  logic                 out_free;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [NOW_W-1:0]     wr_data;
  logic [NOW_W-1:0]     rd_data;

  // Start time log
  swsl_ram #(
    .WIDTH (NOW_W),
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_log (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Decisions shared by the state machine and the datapath
  assign accept   = s_tvalid && s_tready;
  assign bypass   = (s_tuser == CMD_CHECK) && (burst_q == '0);
  assign out_free = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // Signed age of the entry just read: negative or within the window keeps it
  assign diff    = {1'b0, now_q} - {1'b0, rd_data};
  assign keep    = diff[NOW_W] || (diff[NOW_W-1:0] <= {{(NOW_W-WINDOW_W){1'b0}}, window_q});
  assign hit_now = (burst_q != '0) && (32'(kept) >= 32'(burst_q));
  assign room    = kept < DEPTH_C;
  assign append  = (cmd_q == CMD_ATTEMPT) && !hit_now && room;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (bypass) begin
            state_next = S_RESULT;
          end else if (total == '0) begin
            state_next = S_DECIDE;
          end else begin
            state_next = S_PRUNE;
          end
        end
      end
      S_PRUNE: begin
        if (rd_idx == total && !rd_pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State outputs: request ready, log reads and writes
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = kept[AW-1:0];
    wr_data  = rd_data;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
      end
      S_PRUNE: begin
        issue = (rd_idx != total);
        wr_en = rd_pend && keep;
      end
      S_DECIDE: begin
        wr_en   = append;
        wr_data = now_q;
      end
      S_RESULT: begin
        s_tready = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restart the walk on a request, walk the log, update the count
  always_ff @(posedge clk) begin
    if (rst) begin
      total   <= '0;
      kept    <= '0;
      rd_idx  <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (state == S_IDLE && accept) begin
        rd_idx <= '0;
        kept   <= bypass ? total : '0;
      end
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (state == S_PRUNE && rd_pend && keep) begin
        kept <= kept + 1'b1;
      end
      if (state == S_DECIDE) begin
        kept  <= kept + CW'(append);
        total <= kept + CW'(append);
      end
    end
  end

  // Request payload and decision flags
  logic res_allowed;
  logic res_hit;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      cmd_q       <= s_tuser;
      now_q       <= s_tdata;
      res_allowed <= 1'b1;
      res_hit     <= 1'b0;
    end
    if (state == S_DECIDE) begin
      res_allowed <= !hit_now;
      res_hit     <= hit_now;
    end
  end

  // Result register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      m_tdata <= {{(RES_DATA_W-KEPT_W-2){1'b0}}, KEPT_W'(kept), res_hit, res_allowed};
    end
  end

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      window_q <= WINDOW_RESET;
      burst_q  <= BURST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
        REG_BURST:  burst_q  <= cfg_data[BURST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Checks
  `SWSL_ASSERT_SAME(a_total_bound, 1'b1, total <= DEPTH_C,
    "stored count exceeds log depth")
  `SWSL_ASSERT_SAME(a_kept_bound, state == S_PRUNE, kept <= rd_idx && rd_idx <= total,
    "compaction pointer ran ahead of the read pointer")
  `SWSL_ASSERT_SAME(a_write_state, wr_en, state == S_PRUNE || state == S_DECIDE,
    "log written outside the walk or the append")
  `SWSL_ASSERT_NEXT(a_bypass, accept && bypass, state == S_RESULT && kept == $past(total),
    "check with limiting off did not skip the walk")
  `SWSL_ASSERT_NEXT(a_pend_walk, issue, state == S_PRUNE && rd_pend,
    "log read issued without a pending compare")

endmodule

// ----- test/tb.sv -----
// Testbench for sliding_window_start_limiter_top: attempt and check requests with random
// gaps and stalls, checked field by field against an in-bench model of the start log.
// Depends on swsl_pkg and the limiter RTL; reads no files.
`timescale 1ns / 100ps

module tb;
  import swsl_pkg::*;

  localparam int unsigned LOG_DEPTH   = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 105;

  typedef struct packed {
    logic             cmd;
    logic [NOW_W-1:0] now;
  } start_req_t;

  typedef struct packed {
    logic              allowed;
    logic              limit_hit;
    logic [KEPT_W-1:0] kept;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [NOW_W-1:0]      s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RES_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Requests waiting to be sent and verdicts waiting to arrive
  start_req_t  pending_reqs[$];
  verdict_t    expected_verdicts[$];
  int unsigned reqs_queued = 0;
  int unsigned reqs_accepted = 0;
  int unsigned mismatches = 0;
  bit          no_idle = 1'b0;

  // Model of the start log and the registers
  logic [NOW_W-1:0]    log_times[LOG_DEPTH];
  int unsigned         log_count = 0;
  logic [WINDOW_W-1:0] cur_window = WINDOW_RESET;
  logic [BURST_W-1:0]  cur_burst = BURST_RESET;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  sliding_window_start_limiter_top #(
    .HISTORY_DEPTH(LOG_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial forever #10 clk = ~clk;

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // Prune the log, decide the request, append a permitted attempt if there is room
  function automatic verdict_t limiter_decide(start_req_t r);
    verdict_t    v;
    int unsigned kept;
    longint      age;
    longint      now_l;
    longint      win_l;
    v.allowed   = 1'b1;
    v.limit_hit = 1'b0;
    if (!(r.cmd == CMD_CHECK && cur_burst == 0)) begin
      kept  = 0;
      now_l = r.now;
      win_l = cur_window;
      for (int i = 0; i < log_count; i++) begin
        age = now_l - longint'(log_times[i]);
        if (age <= win_l) begin
          log_times[kept] = log_times[i];
          kept++;
        end
      end
      log_count = kept;
      if (cur_burst != 0 && log_count >= cur_burst) begin
        v.allowed   = 1'b0;
        v.limit_hit = 1'b1;
      end else if (r.cmd == CMD_ATTEMPT && log_count < LOG_DEPTH) begin
        log_times[log_count] = r.now;
        log_count++;
      end
    end
    v.kept = log_count[KEPT_W-1:0];
    return v;
  endfunction

  // Request driver: hold under backpressure, insert a drawn gap after each request
  always @(posedge clk) begin : req_driver
    start_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= r.now;
        s_tuser  <= r.cmd;
        gap_left <= idle_draw();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: track register writes, predict accepted requests, check results
  always @(posedge clk) begin : result_monitor
    verdict_t    want;
    verdict_t    got;
    int unsigned st;
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      log_count  = 0;
      cur_window = WINDOW_RESET;
      cur_burst  = BURST_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW)
          cur_window = cfg_data[WINDOW_W-1:0];
        else if (cfg_index == REG_BURST)
          cur_burst = cfg_data[BURST_W-1:0];
      end
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back(limiter_decide('{cmd: s_tuser, now: s_tdata}));
        reqs_accepted++;
      end
      st = stall_left;
      if (m_tvalid && m_tready) begin
        got.allowed   = m_tdata[0];
        got.limit_hit = m_tdata[1];
        got.kept      = m_tdata[2 +: KEPT_W];
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with nothing expected, got %p", $time, got);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.allowed !== want.allowed) begin
            $display("%0t: allowed expected %0d got %0d", $time, want.allowed, got.allowed);
            mismatches++;
          end
          if (got.limit_hit !== want.limit_hit) begin
            $display("%0t: limit_hit expected %0d got %0d", $time, want.limit_hit,
                     got.limit_hit);
            mismatches++;
          end
          if (got.kept !== want.kept) begin
            $display("%0t: kept_count expected %0d got %0d", $time, want.kept, got.kept);
            mismatches++;
          end
        end
        st = idle_draw();
      end
      // Hold the result side stalled until the drawn stall runs out
      if (st != 0) begin
        m_tready   <= 1'b0;
        stall_left <= st - 1;
      end else begin
        m_tready   <= 1'b1;
        stall_left <= 0;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_req(logic cmd, logic [NOW_W-1:0] now);
    pending_reqs.push_back('{cmd: cmd, now: now});
    reqs_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is answered, then let the block go quiet
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || reqs_accepted != reqs_queued ||
           expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (LOG_DEPTH + 8) @(posedge clk);
  endtask

  // Mostly advancing times within the window, with jumps, rewinds and noise
  task automatic queue_traffic(int unsigned n, logic [WINDOW_W-1:0] win);
    logic [NOW_W-1:0] t;
    int unsigned      step_max;
    int unsigned      sel;
    logic             cmd;
    t        = $urandom();
    step_max = (win >> 2) + 1;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 75)
        t = t + $urandom_range(0, step_max);
      else if (sel < 85)
        t = t + win + 1 + $urandom_range(0, step_max);
      else if (sel < 92)
        t = t - $urandom_range(0, step_max);
      else
        t = $urandom();
      cmd = ($urandom_range(0, 4) == 0) ? CMD_CHECK : CMD_ATTEMPT;
      queue_req(cmd, t);
    end
  endtask

  initial begin
    logic [WINDOW_W-1:0] win;
    logic [BURST_W-1:0]  burst;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty check, wrap-around prune, rewind, window edge, limit
    queue_req(CMD_CHECK, 32'h0000_0000);
    queue_req(CMD_ATTEMPT, 32'h0000_0000);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFFF);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFF0);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFF5);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFFA);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFFA);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFFF);
    queue_req(CMD_CHECK, 32'hFFFF_FFFF);
    queue_req(CMD_ATTEMPT, 32'hFFFF_FFFF);
    wait_drained();

    // Limiting off, widest window: fill the log past full, then a check skips pruning
    write_reg(REG_BURST, $urandom() & 32'hFFFF_FF00);
    write_reg(REG_WINDOW, $urandom() | 32'h000F_FFFF);
    for (int i = 0; i < LOG_DEPTH + 1; i++)
      queue_req(CMD_ATTEMPT, 32'd1000 + i);
    queue_req(CMD_CHECK, 32'h8000_0000);
    wait_drained();

    // Random phases, each under its own register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          win   = '0;
          burst = 8'd1;
        end
        1: begin
          win   = '1;
          burst = '1;
        end
        2: begin
          win   = 20'd3;
          burst = 8'(LOG_DEPTH);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: win = $urandom_range(0, 40);
            1: win = $urandom_range(0, 2000);
            2: win = $urandom_range(0, 20'hFFFFF);
            default: win = $urandom_range(0, 8);
          endcase
          case ($urandom_range(0, 3))
            0: burst = $urandom_range(0, 255);
            1: burst = '1;
            default: burst = $urandom_range(0, LOG_DEPTH + 1);
          endcase
        end
      endcase
      // Unknown indexes must leave both registers alone
      write_reg(CFG_IDX_W'($urandom_range(2, 255)), $urandom());
      write_reg(REG_WINDOW, ($urandom() & 32'hFFF0_0000) | win);
      write_reg(REG_BURST, ($urandom() & 32'hFFFF_FF00) | burst);
      no_idle = ($urandom_range(0, 3) == 0);
      queue_traffic(PHASE_ITEMS, win);
      wait_drained();
    end

    repeat (LOG_DEPTH + 8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/swsl_pkg.sv
sv/swsl_ram.sv
sv/sliding_window_start_limiter_top.sv
test/tb.sv
